// File: rtl/rmac_pkg.sv
// ----------------------------------------------------------------------------
// rmac_pkg
// Shared types and fixed port widths for the running median / cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmac_pkg;

  localparam int SAMPLE_IN_W = 16;
  localparam int MEDIAN_W    = 16;
  localparam int COST_W      = 21;
  localparam int COUNT_W     = 7;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage

`default_nettype wire

// File: rtl/rmac_cell.sv
// ----------------------------------------------------------------------------
// rmac_cell
// One slot of the sorted chain. Compares its entry with the new sample and,
// on insert, keeps its entry, takes the left neighbor's, or takes the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rmac_cell #(
  parameter int IDX   = 0,
  parameter int SW    = 16,
  parameter int CNT_W = 7
) (
  input  wire logic                 clk,
  input  wire logic                 ins,
  input  wire logic signed [SW-1:0] sample,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic signed [SW-1:0] left_val,
  input  wire logic                 left_gt,
  output logic signed [SW-1:0]      val,
  output logic                      gt
);

  logic occupied;
  logic at_end;

  assign occupied = count > CNT_W'(IDX);
  assign at_end   = count == CNT_W'(IDX);
  assign gt       = occupied && (val > sample);

  always_ff @(posedge clk) begin
    if (ins && (gt || at_end)) begin
      val <= left_gt ? left_val : sample;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmac_chain.sv
// ----------------------------------------------------------------------------
// rmac_chain
// Row of sorted cells with the half-split flag for the insert and two read
// taps used to pick the median and its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module rmac_chain #(
  parameter int CAPACITY = 64,
  parameter int SW       = 16,
  parameter int CNT_W    = 7
) (
  input  wire logic                 clk,
  input  wire logic                 ins,
  input  wire logic signed [SW-1:0] sample,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic [CNT_W-1:0]     tap_idx,
  output logic                      lo_side,
  output logic signed [SW-1:0]      tap_val,
  output logic signed [SW-1:0]      tap_nxt
);

  logic signed [SW-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]  gts;
  logic [CNT_W-1:0]     half_idx;
  logic [CNT_W-1:0]     nxt_idx;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        rmac_cell #(.IDX(i), .SW(SW), .CNT_W(CNT_W)) u_cell (
          .clk      (clk),
          .ins      (ins),
          .sample   (sample),
          .count    (count),
          .left_val ({SW{1'b0}}),
          .left_gt  (1'b0),
          .val      (vals[i]),
          .gt       (gts[i])
        );
      end else begin : g_body
        rmac_cell #(.IDX(i), .SW(SW), .CNT_W(CNT_W)) u_cell (
          .clk      (clk),
          .ins      (ins),
          .sample   (sample),
          .count    (count),
          .left_val (vals[i-1]),
          .left_gt  (gts[i-1]),
          .val      (vals[i]),
          .gt       (gts[i])
        );
      end
    end
  endgenerate

  assign half_idx = count >> 1;
  assign nxt_idx  = tap_idx + CNT_W'(1);

  always_comb begin
    logic half_gt;
    half_gt = 1'b0;
    tap_val = '0;
    tap_nxt = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      half_gt = half_gt | (gts[j] & (half_idx == CNT_W'(j)));
      tap_val = tap_val | (vals[j] & {SW{tap_idx == CNT_W'(j)}});
      tap_nxt = tap_nxt | (vals[j] & {SW{nxt_idx == CNT_W'(j)}});
    end
    // new sample lands in the lower half when the store is empty or the entry at the split is greater than the sample
    lo_side = (count == '0) || half_gt;
  end

endmodule

`default_nettype wire

// File: rtl/running_median_abs_cost_core.sv
// ----------------------------------------------------------------------------
// running_median_abs_cost_core
// Running lower median and total absolute deviation over all kept samples,
// kept in a sorted chain of cells with incremental half sums.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   sample
//  out      source     out_valid / out_stall median, cost, count, dropped
//
//  On each beat the chain inserts on the accept edge, then the ST_CALC state
//  selects the median taps, updates the half sums and forms the cost.
//  Reset clears the count, sums and handshake state; cell contents are not
//  reset. A stalled output holds its beat; a new input is taken once the
//  output is free or taken on the same edge. A full store drops the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_abs_cost_core #(
  parameter int CAPACITY     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [rmac_pkg::SAMPLE_IN_W-1:0] sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [rmac_pkg::MEDIAN_W-1:0]        median,
  output logic [rmac_pkg::COST_W-1:0]                 cost,
  output logic [rmac_pkg::COUNT_W-1:0]                count,
  output logic                                        dropped
);

  import rmac_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = SW + $clog2(CAPACITY) + 1;
  localparam int CALC_W = (SUM_W + 1 > COST_W + 2) ? SUM_W + 1 : COST_W + 2;
  localparam logic signed [CALC_W-1:0] COST_MAX = CALC_W'((1 << COST_W) - 1);

  state_t st;
  state_t st_next;

  logic                     calc;
  logic                     in_acc;
  logic                     out_acc;
  logic                     full;
  logic                     ins;
  logic signed [SW-1:0]     s_ext;

  logic [CNT_W-1:0]         kept_count;
  logic signed [SUM_W-1:0]  lower_sum;
  logic signed [SUM_W-1:0]  upper_sum;
  logic signed [SW-1:0]     s_q;
  logic                     lo_q;
  logic                     drop_q;
  logic signed [MEDIAN_W-1:0] med_last;
  logic [COST_W-1:0]        cost_last;

  logic                     lo_side;
  logic [CNT_W-1:0]         tap_idx;
  logic signed [SW-1:0]     tap_val;
  logic signed [SW-1:0]     tap_nxt;

  logic signed [SUM_W-1:0]  lower_next;
  logic signed [SUM_W-1:0]  upper_next;
  logic signed [CALC_W-1:0] cost_full;
  logic [COST_W-1:0]        cost_clamp;

  generate
    if (SW <= SAMPLE_IN_W) begin : g_narrow
      assign s_ext = sample[SW-1:0];
    end else begin : g_wide
      assign s_ext = {{(SW - SAMPLE_IN_W){1'b0}}, sample};
    end
  endgenerate

  assign full    = kept_count == CNT_W'(CAPACITY);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign ins     = in_acc && !full;

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (in_acc) st_next = ST_CALC;
      ST_CALC: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (st)
      ST_CALC: calc = 1'b1;
      default: calc = 1'b0;
    endcase
    in_stall = calc || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  assign tap_idx = (kept_count - CNT_W'(1)) >> 1;

  rmac_chain #(.CAPACITY(CAPACITY), .SW(SW), .CNT_W(CNT_W)) u_chain (
    .clk     (clk),
    .ins     (ins),
    .sample  (s_ext),
    .count   (kept_count),
    .tap_idx (tap_idx),
    .lo_side (lo_side),
    .tap_val (tap_val),
    .tap_nxt (tap_nxt)
  );

  // kept_count already holds the new count here; odd new count means the
  // lower half grew by one
  always_comb begin
    logic signed [SUM_W-1:0] s_w;
    logic signed [SUM_W-1:0] ak;
    logic signed [SUM_W-1:0] ak1;
    logic signed [CALC_W-1:0] med_term;
    s_w        = SUM_W'(s_q);
    ak         = SUM_W'(tap_val);
    ak1        = SUM_W'(tap_nxt);
    lower_next = lower_sum;
    upper_next = upper_sum;
    if (kept_count[0]) begin
      if (lo_q) begin
        lower_next = lower_sum + s_w;
      end else begin
        lower_next = lower_sum + ak;
        upper_next = upper_sum + s_w - ak;
      end
    end else begin
      if (lo_q) begin
        lower_next = lower_sum + s_w - ak1;
        upper_next = upper_sum + ak1;
      end else begin
        upper_next = upper_sum + s_w;
      end
    end
    med_term  = kept_count[0] ? CALC_W'(tap_val) : '0;
    cost_full = med_term - CALC_W'(lower_next) + CALC_W'(upper_next);
    if (cost_full < 0) begin
      cost_clamp = '0;
    end else if (cost_full > COST_MAX) begin
      cost_clamp = COST_MAX[COST_W-1:0];
    end else begin
      cost_clamp = cost_full[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      lower_sum  <= '0;
      upper_sum  <= '0;
      med_last   <= '0;
      cost_last  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ins) begin
        kept_count <= kept_count + CNT_W'(1);
      end
      if (calc) begin
        out_valid <= 1'b1;
        if (!drop_q) begin
          lower_sum <= lower_next;
          upper_sum <= upper_next;
          med_last  <= MEDIAN_W'(tap_val);
          cost_last <= cost_clamp;
        end
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_q    <= s_ext;
      lo_q   <= lo_side;
      drop_q <= full;
    end
    if (calc) begin
      median  <= drop_q ? med_last : MEDIAN_W'(tap_val);
      cost    <= drop_q ? cost_last : cost_clamp;
      count   <= COUNT_W'(kept_count);
      dropped <= drop_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CNT_W'(CAPACITY))
    else $error("kept count beyond capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##2 out_valid)
    else $error("no result beat two cycles after input beat");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !full |=> kept_count == $past(kept_count) + CNT_W'(1))
    else $error("kept count did not advance on insert");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    calc && drop_q |-> kept_count == CNT_W'(CAPACITY))
    else $error("drop flagged while store not full");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    calc |-> !out_valid)
    else $error("result register still occupied at result load");

endmodule

`default_nettype wire

// File: test/rmac_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmac_tb_pkg
// Result type and scoreboard for the running median / cost testbench. The
// scoreboard keeps its own sorted copy of every kept sample. It works out the
// median, cost, count and drop flag for each accepted sample and checks the
// results, in order, as they leave the block.
// ----------------------------------------------------------------------------
package rmac_tb_pkg;

  import rmac_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam longint COST_CEIL = (64'd1 << COST_W) - 1;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median;
    logic [COST_W-1:0]          cost;
    logic [COUNT_W-1:0]         count;
    logic                       dropped;
  } median_result_t;

  class median_cost_scoreboard;
    logic signed [SAMPLE_IN_W-1:0] ordered [STORE_DEPTH];
    int unsigned    held;
    median_result_t awaiting [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    drops;
    longint         peak_cost;

    function new();
      held      = 0;
      errors    = 0;
      checked   = 0;
      drops     = 0;
      peak_cost = 0;
    endfunction

    // insert the sample in order (after equal entries) and predict the result
    function void note_sample(logic signed [SAMPLE_IN_W-1:0] s);
      median_result_t r;
      int     slot;
      int     i;
      longint lo_n;
      longint up_n;
      longint lo_sum;
      longint up_sum;
      longint mid;
      longint total;
      r.dropped = (held >= STORE_DEPTH);
      if (r.dropped) begin
        drops++;
      end else begin
        slot = 0;
        while (slot < held && ordered[slot] <= s) slot++;
        for (i = held; i > slot; i--) ordered[i] = ordered[i-1];
        ordered[slot] = s;
        held++;
      end
      lo_n   = (held + 1) / 2;
      up_n   = held - lo_n;
      lo_sum = 0;
      up_sum = 0;
      for (i = 0; i < held; i++) begin
        if (i < lo_n) lo_sum += ordered[i];
        else up_sum += ordered[i];
      end
      mid   = (lo_n > 0) ? longint'(ordered[lo_n-1]) : 0;
      total = mid * lo_n - lo_sum + up_sum - mid * up_n;
      if (total < 0) total = 0;
      if (total > COST_CEIL) total = COST_CEIL;
      if (total > peak_cost) peak_cost = total;
      r.median = mid[MEDIAN_W-1:0];
      r.cost   = total[COST_W-1:0];
      r.count  = held[COUNT_W-1:0];
      awaiting.push_back(r);
    endfunction

    function void check_result(logic signed [MEDIAN_W-1:0] m, logic [COST_W-1:0] c,
                               logic [COUNT_W-1:0] n, logic d);
      median_result_t want;
      if (awaiting.size() == 0) begin
        $error("result beat with no sample pending: median %0d cost %0d count %0d",
               m, c, n);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      checked++;
      if (m !== want.median) begin
        $error("median: expected %0d, got %0d", want.median, m);
        errors++;
      end
      if (c !== want.cost) begin
        $error("cost: expected %0d, got %0d", want.cost, c);
        errors++;
      end
      if (n !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, n);
        errors++;
      end
      if (d !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, d);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: test/running_median_abs_cost_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_abs_cost_core_tb
// Drives signed samples into the running median block: a directed opening
// with extreme and repeated values, then random samples that fill the store
// and keep going well past full. Both handshake sides idle at random, with a
// long stretch of back-to-back beats. Every result beat is checked against
// the scoreboard's prediction.
// ----------------------------------------------------------------------------
module running_median_abs_cost_core_tb;

  import rmac_pkg::*;
  import rmac_tb_pkg::*;

  localparam int RANDOM_BEATS = 1384;
  localparam int CYCLE_LIMIT  = 400000;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_IN_W-1:0]  sample;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [MEDIAN_W-1:0]     median;
  logic [COST_W-1:0]              cost;
  logic [COUNT_W-1:0]             count;
  logic                           dropped;

  median_cost_scoreboard sb;
  bit          steady = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;

  logic signed [SAMPLE_IN_W-1:0] opening [16] = '{
    -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768, 16'sd0,
    16'sh5555, 16'shAAAA, 16'sd32766, -16'sd32767, 16'sd2, -16'sd2, 16'sd100, -16'sd100
  };

  running_median_abs_cost_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .median    (median),
    .cost      (cost),
    .count     (count),
    .dropped   (dropped)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.awaiting.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(median, cost, count, dropped);
  end

  // valid stays up after a beat; the next call may idle it or reuse it, and wait_for_results drops it
  task automatic send_sample(input logic signed [SAMPLE_IN_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    sb.note_sample(v);
    sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    int pick;
    logic signed [SAMPLE_IN_W-1:0] v;
    sb       = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    sample   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_sample(opening[i]);
    wait_for_results();

    for (k = 0; k < RANDOM_BEATS; k++) begin
      steady = (k >= 300 && k < 600);
      if (k == 48 || k == 700) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        case ($urandom_range(0, 3))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = 16'sd0;
          default: v = -16'sd1;
        endcase
      end else if (pick < 50) begin
        v = $signed(16'($urandom_range(0, 32))) - 16'sd16;
      end else begin
        v = 16'($urandom);
      end
      send_sample(v);
    end
    steady = 1'b0;

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("%0d samples sent: %0d kept in sorted order, %0d refused by the full store",
             sent, sent - sb.drops, sb.drops);
    $display("%0d result beats checked, largest cost predicted %0d", sb.checked,
             sb.peak_cost);
    if (sb.errors == 0 && sb.awaiting.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rmac_pkg.sv
rtl/rmac_cell.sv
rtl/rmac_chain.sv
rtl/running_median_abs_cost_core.sv
test/rmac_tb_pkg.sv
test/running_median_abs_cost_core_tb.sv
